// ===== rtl/sha256_stream_hasher_top_macros.svh =====
// Assertion macros for the SHA-256 stream hasher top level.
// Used by sha256_stream_hasher_top.sv; expects i_clk and i_rst_n in scope.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shs_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package shs_pkg;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic       shift_en;
        t_byte_sel  byte_sel;
        logic [2:0] len_idx;
        logic       count_bits;
        logic       load_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold;
        logic       restart;
        logic [2:0] word_idx;
    } t_dp_cmd;

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        return K_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shs_if.sv =====
// Stream channel interfaces: message bytes in, digest words out.
// Depends on nothing; used by the top level.
`default_nettype none

interface shs_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface shs_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/shs_datapath.sv =====
// SHA-256 datapath: message window/schedule, working vars, chain words, bit count.
// Depends on shs_pkg; driven by shs_ctrl commands.
`default_nettype none

module shs_datapath
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic      [31:0] o_digest_word
);

    logic [31:0] r_win [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [63:0] r_bits;

    logic [7:0]  byte_in;
    logic [5:0]  len_shift;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    assign len_shift = {3'd7 - i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: byte_in = i_data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_ZERO: byte_in = 8'h00;
            SEL_LEN:  byte_in = r_bits[len_shift +: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    // window holds w[t..t+15]; next word from taps 0, 1, 9, 14
    assign w_new = sig1(r_win[14]) + r_win[9] + sig0(r_win[1]) + r_win[0];

    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + k_const(i_cmd.round_idx) + r_win[0];
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], byte_in};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= IV[i];
            end
            r_bits <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.count_bits) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    assign o_digest_word = r_h[i_cmd.word_idx];

endmodule

`default_nettype wire

// ===== rtl/shs_ctrl.sv =====
// SHA-256 controller: byte intake, padding sequence, round counting, digest output.
// Depends on shs_pkg; commands shs_datapath.
`default_nettype none

module shs_ctrl
    import shs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_byte_valid,
    input  wire logic       i_end_of_message,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [2:0] o_word_index,
    output logic            o_last_word,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PAD80  = 7'b0000010,
        S_PADZ   = 7'b0000100,
        S_PADLEN = 7'b0001000,
        S_COMP   = 7'b0010000,
        S_FOLD   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;
    t_dp_cmd    cmd;

    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_fill        = r_fill;
        n_round       = r_round;
        n_widx        = r_widx;
        cmd           = '0;
        cmd.byte_sel  = SEL_DATA;
        cmd.len_idx   = r_fill[2:0];
        cmd.round_idx = r_round;
        cmd.word_idx  = r_widx;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_valid) begin
                        cmd.shift_en   = 1'b1;
                        cmd.count_bits = 1'b1;
                        n_fill         = r_fill + 6'd1;
                        if (r_fill == FILL_LAST) begin
                            cmd.load_work = 1'b1;
                            n_round       = '0;
                            n_state       = S_COMP;
                            n_ret         = i_end_of_message ? S_PAD80 : S_IDLE;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD80;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_PAD;
                n_fill       = r_fill + 6'd1;
                n_state      = S_PADZ;
                if (r_fill == FILL_LAST) begin
                    cmd.load_work = 1'b1;
                    n_round       = '0;
                    n_state       = S_COMP;
                    n_ret         = S_PADZ;
                end
            end
            S_PADZ: begin
                if (r_fill == LEN_POS) begin
                    n_state = S_PADLEN;
                end else begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    n_fill       = r_fill + 6'd1;
                    if (r_fill == FILL_LAST) begin
                        cmd.load_work = 1'b1;
                        n_round       = '0;
                        n_state       = S_COMP;
                        n_ret         = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_LEN;
                n_fill       = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    cmd.load_work = 1'b1;
                    n_round       = '0;
                    n_state       = S_COMP;
                    n_ret         = S_EMIT;
                end
            end
            S_COMP: begin
                cmd.round_en = 1'b1;
                n_round      = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
                n_widx   = '0;
                n_state  = r_ret;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == WORD_LAST) begin
                        cmd.restart = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

    assign o_cmd        = cmd;
    assign o_word_index = r_widx;
    assign o_last_word  = (r_widx == WORD_LAST);

endmodule

`default_nettype wire

// ===== rtl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher. One message byte per input transfer; a transfer with
// end_of_message pads the message and produces the digest as eight 32-bit words,
// H0 first, then the hasher starts over from the initial hash values. The 64th
// byte of a block starts a compression in the single round unit: 64 rounds plus
// a fold step, with input held off until the hasher is back in idle. On the end
// transfer, padding is shifted in one byte per cycle up to the block end, apart
// from a compression when a block fills (a second block when fewer than nine
// bytes remain); each padded block is compressed, and the eight digest words
// follow as eight output transfers.
// Depends on shs_pkg, shs_if, shs_ctrl, shs_datapath and the macros header.
`default_nettype none

`include "sha256_stream_hasher_top_macros.svh"

module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_msg_if.sink   i_msg,
    shs_dig_if.source o_dig
);

    t_dp_cmd cmd;

    shs_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .i_byte_valid     (i_msg.byte_valid),
        .i_end_of_message (i_msg.end_of_message),
        .o_in_ready       (i_msg.ready),
        .o_out_valid      (o_dig.valid),
        .i_out_ready      (o_dig.ready),
        .o_word_index     (o_dig.word_index),
        .o_last_word      (o_dig.last_word),
        .o_cmd            (cmd)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_msg.data_byte),
        .o_digest_word (o_dig.digest_word)
    );

    `SHS_ASSERT_NOW(a_no_overlap, i_msg.ready, !o_dig.valid, "input open while digest pending")
    `SHS_ASSERT_NEXT(a_word_step, o_dig.valid && o_dig.ready && !o_dig.last_word, o_dig.valid && (o_dig.word_index == $past(o_dig.word_index) + 3'd1), "digest word sequence broken")
    `SHS_ASSERT_NEXT(a_back_idle, o_dig.valid && o_dig.ready && o_dig.last_word, i_msg.ready && !o_dig.valid, "not idle after digest")

endmodule

`default_nettype wire
